// File: rtl/sitdt_pkg.sv
// Package for the signed integer to decimal text block.
// Holds the value width, the BCD digit count, the ASCII codes and the sequencer state type.
// Depends on nothing.
`default_nettype none

package sitdt_pkg;

  localparam int VALUE_WIDTH = 64;
  // Enough BCD digits for a magnitude of up to 2^(VALUE_WIDTH-1).
  localparam int NUM_DIGITS  = (VALUE_WIDTH * 3) / 10 + 1;
  localparam int BCD_WIDTH   = NUM_DIGITS * 4;
  localparam int BIT_CNT_W   = $clog2(VALUE_WIDTH + 1);
  localparam int DIG_CNT_W   = $clog2(NUM_DIGITS + 1);

  localparam logic [7:0] CH_ZERO    = 8'd48;
  localparam logic [7:0] CH_MINUS   = 8'd45;
  localparam logic [7:0] CH_NEWLINE = 8'd10;
  localparam logic [3:0] BCD_MAX    = 4'd9;

  typedef enum logic [5:0] {
    S_IDLE    = 6'b000001,
    S_CONV    = 6'b000010,
    S_SKIP    = 6'b000100,
    S_SIGN    = 6'b001000,
    S_DIGIT   = 6'b010000,
    S_NEWLINE = 6'b100000
  } state_t;

endpackage

`default_nettype wire

// File: rtl/signed_int_to_decimal_text_top.sv
// Top level of the signed integer to decimal text block: bit-serial double dabble
// converter and a byte sequencer with a registered output word.
// Depends on sitdt_pkg.
//
// Usage:
//   The input channel (in_valid/in_ready) takes one word: a two's-complement value
//   and an end_line flag. The output channel (out_valid/out_ready) gives the text as
//   a run of byte words: '-' for a negative value, the decimal digits most
//   significant first without leading zeros, then newline 10 when end_line is set.
//   The final word of a run has last set.
//   Only the low VALUE_WIDTH bits of value are used, bit VALUE_WIDTH-1 as sign.
//   Timing: the magnitude is shifted into a BCD register one bit per cycle, and
//   leading zero digits are then dropped one per cycle. The bytes go out at one
//   per cycle while the receiver keeps out_ready high; in_ready is high only
//   between values.
//   When the receiver stalls, the output word holds and the sequencer waits.
//   Reset (rst, synchronous) returns the sequencer to idle and drops out_valid.
`default_nettype none

module signed_int_to_decimal_text_top
  import sitdt_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [63:0] value,
  input  wire logic        end_line,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [7:0]       text_byte,
  output logic             last
);

  state_t                   state, state_next;
  logic [VALUE_WIDTH-1:0]   mag, mag_next;
  logic [BCD_WIDTH-1:0]     bcd, bcd_next;
  logic [BIT_CNT_W-1:0]     bit_cnt, bit_cnt_next;
  logic [DIG_CNT_W-1:0]     dig_cnt, dig_cnt_next;
  logic                     neg, neg_next;
  logic                     nl, nl_next;
  logic                     out_valid_next;
  logic [7:0]               text_byte_next;
  logic                     last_next;

  logic                     in_fire;
  logic                     slot_free;
  logic [VALUE_WIDTH-1:0]   v_in;
  logic [3:0]               top_digit;
  logic [BCD_WIDTH-1:0]     bcd_adj;
  logic                     emit;

  // Add 3 to every digit above 4 ahead of the shift (digits are independent).
  function automatic logic [BCD_WIDTH-1:0] dabble(input logic [BCD_WIDTH-1:0] b);
    logic [BCD_WIDTH-1:0] r;
    r = b;
    for (int i = 0; i < NUM_DIGITS; i++) begin
      if (b[i*4 +: 4] > 4'd4) begin
        r[i*4 +: 4] = b[i*4 +: 4] + 4'd3;
      end
    end
    return r;
  endfunction

  assign in_ready  = (state == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign slot_free = !out_valid || out_ready;
  assign v_in      = value[VALUE_WIDTH-1:0];
  assign top_digit = bcd[BCD_WIDTH-1 -: 4];
  assign bcd_adj   = dabble(bcd);

  always_comb begin
    state_next     = state;
    mag_next       = mag;
    bcd_next       = bcd;
    bit_cnt_next   = bit_cnt;
    dig_cnt_next   = dig_cnt;
    neg_next       = neg;
    nl_next        = nl;
    text_byte_next = text_byte;
    last_next      = last;
    emit           = 1'b0;

    case (state)
      S_IDLE: begin
        if (in_fire) begin
          neg_next     = v_in[VALUE_WIDTH-1];
          nl_next      = end_line;
          mag_next     = v_in[VALUE_WIDTH-1] ? (~v_in + 1'b1) : v_in;
          bcd_next     = '0;
          bit_cnt_next = BIT_CNT_W'(VALUE_WIDTH);
          state_next   = S_CONV;
        end
      end
      S_CONV: begin
        bcd_next     = {bcd_adj[BCD_WIDTH-2:0], mag[VALUE_WIDTH-1]};
        mag_next     = {mag[VALUE_WIDTH-2:0], 1'b0};
        bit_cnt_next = bit_cnt - 1'b1;
        if (bit_cnt == BIT_CNT_W'(1)) begin
          dig_cnt_next = DIG_CNT_W'(NUM_DIGITS);
          state_next   = S_SKIP;
        end
      end
      S_SKIP: begin
        if (top_digit == 4'd0 && dig_cnt > DIG_CNT_W'(1)) begin
          bcd_next     = {bcd[BCD_WIDTH-5:0], 4'd0};
          dig_cnt_next = dig_cnt - 1'b1;
        end else begin
          state_next = neg ? S_SIGN : S_DIGIT;
        end
      end
      S_SIGN: begin
        if (slot_free) begin
          emit           = 1'b1;
          text_byte_next = CH_MINUS;
          last_next      = 1'b0;
          state_next     = S_DIGIT;
        end
      end
      S_DIGIT: begin
        if (slot_free) begin
          emit           = 1'b1;
          text_byte_next = CH_ZERO + {4'd0, (top_digit > BCD_MAX) ? BCD_MAX : top_digit};
          last_next      = (dig_cnt == DIG_CNT_W'(1)) && !nl;
          bcd_next       = {bcd[BCD_WIDTH-5:0], 4'd0};
          dig_cnt_next   = dig_cnt - 1'b1;
          if (dig_cnt == DIG_CNT_W'(1)) begin
            state_next = nl ? S_NEWLINE : S_IDLE;
          end
        end
      end
      S_NEWLINE: begin
        if (slot_free) begin
          emit           = 1'b1;
          text_byte_next = CH_NEWLINE;
          last_next      = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase

    if (emit) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      bit_cnt   <= '0;
      dig_cnt   <= '0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
      bit_cnt   <= bit_cnt_next;
      dig_cnt   <= dig_cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    mag       <= mag_next;
    bcd       <= bcd_next;
    neg       <= neg_next;
    nl        <= nl_next;
    text_byte <= text_byte_next;
    last      <= last_next;
  end

  // The conversion hands over to digit trimming after its last bit.
  a_conv_end: assert property (@(posedge clk) disable iff (rst)
    (state == S_CONV && bit_cnt == BIT_CNT_W'(1)) |=> (state == S_SKIP))
    else $error("conversion did not hand over to digit trimming");

  // A digit is only sent while at least one digit remains.
  a_digit_count: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIGIT) |-> (dig_cnt != '0))
    else $error("digit state entered with no digits left");

  // The word marked last closes the run and frees the input side.
  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    (emit && last_next) |=> (state == S_IDLE && out_valid && last))
    else $error("final word did not return the sequencer to idle");

  // An accepted value starts a full-length conversion on the next cycle.
  a_accept_conv: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> (state == S_CONV && bit_cnt == BIT_CNT_W'(VALUE_WIDTH)))
    else $error("accepted value did not start conversion");

endmodule

`default_nettype wire

// File: tb/tb_signed_int_to_decimal_text_top.sv
// Self-checking testbench for signed_int_to_decimal_text_top: numbers go in, decimal text
// bytes come out and are compared against a behavioral formatter kept in this file.
// Depends on sitdt_pkg and the RTL of the block; needs no other file.
`default_nettype none

module tb_signed_int_to_decimal_text_top;
  import sitdt_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0] ch;
    logic       eol;
  } text_char_t;

  typedef struct packed {
    logic [63:0] num;
    logic        nl;
  } number_req_t;

  typedef enum logic [1:0] {
    RX_STREAM,
    RX_COIN,
    RX_EVERY_THIRD,
    RX_SPARSE
  } rx_mode_t;

  localparam int NUM_CORNERS = 21;
  localparam logic [63:0] CORNER_VALUES [NUM_CORNERS] = '{
    64'd0, 64'd1, -64'sd1, 64'd9, -64'sd9, 64'd10, -64'sd10, 64'd99, 64'd100, -64'sd100,
    64'h7FFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000, 64'h8000_0000_0000_0001,
    64'h7FFF_FFFF_FFFF_FFFE, 64'd1000000000000000000, 64'd999999999999999999,
    -64'sd1000000000000000000, 64'd1234567890, -64'sd9876543210, 64'd4294967296,
    -64'sd2147483648
  };
  localparam int NUM_RANDOM = 336;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [63:0] value = '0;
  logic        end_line = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  text_byte;
  logic        last;

  number_req_t numbers_to_send [$];
  text_char_t  expected_text [$];

  logic        in_taken = 1'b0;
  int          burst_left = 0;
  int          gap_left = 0;
  rx_mode_t    rx_mode = RX_STREAM;
  int          rx_phase_left = 0;
  int unsigned rx_tick = 0;

  int mismatches = 0;
  int numbers_taken = 0;
  int negatives_taken = 0;
  int newlines_taken = 0;
  int bytes_checked = 0;
  int longest_run = 0;

  signed_int_to_decimal_text_top dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .value    (value),
    .end_line (end_line),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .text_byte(text_byte),
    .last     (last)
  );

  always #2 clk = ~clk;

  // Formats one number the way the block should and queues the resulting bytes.
  function automatic void format_decimal(input logic [63:0] num, input logic nl);
    logic [VALUE_WIDTH-1:0] v;
    logic [VALUE_WIDTH-1:0] negated;
    logic [63:0]            mag;
    logic [7:0]             digits [24];
    int                     nd;
    text_char_t             run [$];
    text_char_t             tc;
    v = num[VALUE_WIDTH-1:0];
    negated = ~v + 1'b1;
    // The magnitude is unsigned, so the most negative value needs no special handling.
    mag = v[VALUE_WIDTH-1] ? 64'(negated) : 64'(v);
    nd = 0;
    do begin
      digits[nd] = CH_ZERO + 8'(mag % 64'd10);
      mag = mag / 64'd10;
      nd++;
    end while (mag != 0);
    if (v[VALUE_WIDTH-1]) begin
      run.push_back('{ch: CH_MINUS, eol: 1'b0});
      negatives_taken++;
    end
    for (int i = nd - 1; i >= 0; i--) begin
      run.push_back('{ch: digits[i], eol: 1'b0});
    end
    if (nl) begin
      run.push_back('{ch: CH_NEWLINE, eol: 1'b0});
      newlines_taken++;
    end
    tc = run.pop_back();
    tc.eol = 1'b1;
    run.push_back(tc);
    if (run.size() > longest_run) begin
      longest_run = run.size();
    end
    foreach (run[i]) begin
      expected_text.push_back(run[i]);
    end
    numbers_taken++;
  endfunction

  function automatic void report_failure(input string what, input text_char_t exp_c,
                                         input logic [7:0] got_ch, input logic got_eol);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%0t: %s: expected byte %0d last %0b, got byte %0d last %0b",
               $realtime, what, exp_c.ch, exp_c.eol, got_ch, got_eol);
    end
  endfunction

  // Input side: a word is taken at a rising edge with valid and ready both high.
  always @(posedge clk) begin
    in_taken <= !rst && in_valid && in_ready;
    if (!rst && in_valid && in_ready) begin
      format_decimal(value, end_line);
    end
  end

  // Sender: bursts of back-to-back words separated by random gaps.
  always @(negedge clk) begin
    number_req_t req;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_taken) begin
      // Still waiting for the block to take the current word.
    end else if (gap_left != 0) begin
      in_valid <= 1'b0;
      gap_left <= gap_left - 1;
    end else if (numbers_to_send.size() != 0) begin
      req = numbers_to_send.pop_front();
      value <= req.num;
      end_line <= req.nl;
      in_valid <= 1'b1;
      if (burst_left <= 1) begin
        burst_left <= $urandom_range(1, 10);
        gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 120);
      end else begin
        burst_left <= burst_left - 1;
      end
    end else begin
      in_valid <= 1'b0;
    end
  end

  // Receiver: the stall pattern switches at random among the four receive modes.
  always @(negedge clk) begin
    if (rx_phase_left == 0) begin
      rx_mode <= rx_mode_t'($urandom_range(0, 3));
      rx_phase_left <= $urandom_range(50, 300);
    end else begin
      rx_phase_left <= rx_phase_left - 1;
    end
    rx_tick <= rx_tick + 1;
    case (rx_mode)
      RX_STREAM: begin
        out_ready <= 1'b1;
      end
      RX_COIN: begin
        out_ready <= 1'($urandom_range(0, 1));
      end
      RX_EVERY_THIRD: begin
        out_ready <= (rx_tick % 3 == 0);
      end
      default: begin
        out_ready <= ($urandom_range(0, 7) == 0);
      end
    endcase
  end

  // Output side: every accepted word is compared with the oldest expected byte.
  always @(posedge clk) begin
    text_char_t exp_c;
    if (!rst && out_valid === 1'b1 && out_ready) begin
      if (expected_text.size() == 0) begin
        report_failure("unexpected byte", '0, text_byte, last);
      end else begin
        exp_c = expected_text.pop_front();
        bytes_checked++;
        if (text_byte !== exp_c.ch || last !== exp_c.eol) begin
          report_failure("byte mismatch", exp_c, text_byte, last);
        end
      end
    end
  end

  initial begin
    logic [63:0] mag;
    logic [63:0] p10;
    logic        neg;
    int          shape;
    for (int i = 0; i < NUM_CORNERS; i++) begin
      numbers_to_send.push_back('{num: CORNER_VALUES[i], nl: 1'(i % 2)});
    end
    numbers_to_send.push_back('{num: 64'd0, nl: 1'b1});
    numbers_to_send.push_back('{num: 64'h8000_0000_0000_0000, nl: 1'b1});
    numbers_to_send.push_back('{num: 64'h7FFF_FFFF_FFFF_FFFF, nl: 1'b0});
    for (int i = 0; i < NUM_RANDOM; i++) begin
      shape = $urandom_range(0, 99);
      neg = 1'($urandom_range(0, 1));
      p10 = 64'd1;
      for (int k = $urandom_range(1, 19); k > 0; k--) begin
        p10 = p10 * 64'd10;
      end
      if (shape < 40) begin
        mag = {$urandom, $urandom} % p10;
      end else if (shape < 60) begin
        mag = {$urandom, $urandom};
      end else if (shape < 75) begin
        mag = $urandom_range(0, 20);
      end else if (shape < 85) begin
        // Values near the two ends of the range.
        mag = 64'h7FFF_FFFF_FFFF_FFFF - $urandom_range(0, 1000);
        mag = neg ? mag + 64'd1 : mag;
      end else begin
        // A power of ten or one of its neighbors, where the digit count changes.
        mag = p10 + 64'($urandom_range(0, 2)) - 64'd1;
      end
      numbers_to_send.push_back('{num: neg ? -mag : mag, nl: 1'($urandom_range(0, 1))});
    end

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    while (numbers_to_send.size() != 0 || in_valid) @(posedge clk);
    while (expected_text.size() != 0) @(posedge clk);
    // Leave time for any stray byte to show up after the last expected one.
    repeat (200) @(posedge clk);
    while (expected_text.size() != 0) begin
      report_failure("missing byte", expected_text.pop_front(), 8'd0, 1'b0);
    end

    $display("Formatted %0d numbers (%0d negative, %0d with newline), %0d bytes checked.",
             numbers_taken, negatives_taken, newlines_taken, bytes_checked);
    $display("Longest text run was %0d bytes; %0d mismatches.", longest_run, mismatches);
    if (mismatches == 0) begin
      $display("[signed_int_to_decimal_text_top] OK");
    end else begin
      $display("[signed_int_to_decimal_text_top] ERROR");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("Timed out with %0d numbers queued and %0d bytes outstanding.",
             numbers_to_send.size(), expected_text.size());
    $display("[signed_int_to_decimal_text_top] ERROR");
    $finish;
  end

endmodule

`default_nettype wire

// File: signed_int_to_decimal_text_top.f
rtl/sitdt_pkg.sv
rtl/signed_int_to_decimal_text_top.sv
tb/tb_signed_int_to_decimal_text_top.sv
